FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by chained_hash_table_top.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A trigger that must be followed by a condition in the next cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Constants, codes and helpers shared by the chained hash table modules.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int ENTRIES_DEF     = 256;
    localparam int MAX_BUCKETS_DEF = 64;
    localparam int KEY_WIDTH       = 64;
    localparam int VALUE_WIDTH     = 32;

    localparam logic [3:0] DEFAULT_KEY_BYTES = 4'd8;
    localparam logic [6:0] DEFAULT_BUCKETS   = 7'd10;

    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic CFG_KEY_BYTES = 1'b0;
    localparam logic CFG_BUCKETS   = 1'b1;

    // Keeps the low kb bytes of a key; kb is already clamped to 1..8.
    function automatic logic [KEY_WIDTH-1:0] key_mask(input logic [3:0] kb);
        logic [KEY_WIDTH-1:0] m;
        m = '0;
        for (int j = 0; j < 8; j++) begin
            if (4'(j) < kb) begin
                m[8*j +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: rtl/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cht_mod.sv
// ----------------------------------------------------------------------------
// cht_mod
// Bit-serial restoring remainder unit: 64-bit key modulo the bucket count.
// ----------------------------------------------------------------------------
module cht_mod #(
    parameter int DW = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cht_pkg::KEY_WIDTH-1:0]  i_dividend,
    input  logic [DW-1:0]                  i_divisor,
    output logic                           o_done,
    output logic [DW-1:0]                  o_rem
);

    logic [cht_pkg::KEY_WIDTH-1:0] r_dvd;
    logic [DW-1:0]                 r_div;
    logic [DW-1:0]                 r_rem;
    logic [5:0]                    r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [DW:0]                   w_trial;
    logic [DW:0]                   n_rem;

    // One quotient bit per cycle, most significant first.
    always_comb begin
        w_trial = {r_rem, r_dvd[cht_pkg::KEY_WIDTH-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_trial - {1'b0, r_div};
        end else begin
            n_rem = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem[DW-1:0];
                r_dvd <= {r_dvd[cht_pkg::KEY_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/chained_hash_table_top.sv
// ----------------------------------------------------------------------------
// chained_hash_table_top
// Key-value table with separately chained buckets and a fixed entry pool.
// ----------------------------------------------------------------------------
// Usage:
// An item on the request channel (i_valid / o_stall) carries a request type,
// a key and a value. Each item yields exactly one result item on the result
// channel (o_valid / i_stall): a status, a found flag and a value.
// The block handles one item at a time; o_stall is high from acceptance until
// the result is placed in the output register. Between acceptances an item
// passes through the bit-serial remainder unit that picks the bucket, one read
// state and one compare state on the entry memories for every chain entry
// visited, and, for an insert, a pop state and an insert state.
// The output register lets a new item be accepted while a result waits; a
// stalled result holds its value until taken, and a finished item waits for
// the register to free up.
// Reset empties all chains and refills the free pool at once, with no
// clearing pass. Registers key_bytes (index 0) and bucket_count (index 1) are
// written over the configuration channel, which is always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chained_hash_table_top #(
    parameter int ENTRIES     = cht_pkg::ENTRIES_DEF,
    parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_req_type,
    input  logic [cht_pkg::KEY_WIDTH-1:0]   i_key,
    input  logic [cht_pkg::VALUE_WIDTH-1:0] i_value_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [2:0]                      o_status,
    output logic                            o_found,
    output logic [cht_pkg::VALUE_WIDTH-1:0] o_value_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [6:0]                      i_cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int DW = $clog2(MAX_BUCKETS + 1);
    localparam int KW = cht_pkg::KEY_WIDTH;
    localparam int VW = cht_pkg::VALUE_WIDTH;
    localparam logic [LW-1:0] NONE = LW'(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_BKT, S_WALK, S_CMP, S_ACT, S_POP, S_INS, S_OUT
    } t_state;

    t_state             r_state;
    logic [3:0]         r_key_bytes;
    logic [6:0]         r_bucket_cnt;
    logic [1:0]         r_req;
    logic [KW-1:0]      r_key;
    logic [VW-1:0]      r_val_in;
    logic [BW-1:0]      r_bkt;
    logic [LW-1:0]      r_head, r_tail, r_cur, r_prev, r_nx, r_steps;
    logic               r_hit;
    logic [VW-1:0]      r_val;
    logic [IW-1:0]      r_new;
    logic [LW-1:0]      r_free_cnt;
    logic [LW-1:0]      r_mark;
    logic [MAX_BUCKETS-1:0] r_bvalid;
    logic [2:0]         r_res_status;
    logic               r_res_found;
    logic [VW-1:0]      r_res_val;
    logic               r_out_valid;
    logic [2:0]         r_status;
    logic               r_found;
    logic [VW-1:0]      r_vout;

    logic [3:0]         w_kb;
    logic [DW-1:0]      w_div;
    logic               w_accept;
    logic               w_mod_done;
    logic [DW-1:0]      w_rem;
    logic [2*LW-1:0]    w_bkt_rd;
    logic [KW-1:0]      w_key_rd;
    logic [VW-1:0]      w_val_rd;
    logic [LW-1:0]      w_next_rd;
    logic [IW-1:0]      w_free_rd;
    logic [IW-1:0]      w_pop_idx;
    logic [IW-1:0]      w_new;
    logic [LW-1:0]      w_rm_head, w_rm_tail, w_ins_head;

    logic               w_bkt_we, w_bkt_re;
    logic [BW-1:0]      w_bkt_raddr;
    logic [2*LW-1:0]    w_bkt_wdata;
    logic               w_ent_re;
    logic               w_key_we;
    logic               w_val_we;
    logic [IW-1:0]      w_val_waddr;
    logic               w_next_we;
    logic [IW-1:0]      w_next_waddr;
    logic [LW-1:0]      w_next_wdata;
    logic               w_free_we, w_free_re;

    // Effective register values after clamping.
    always_comb begin
        if (r_key_bytes == 4'd0) begin
            w_kb = 4'd1;
        end else if (r_key_bytes > 4'd8) begin
            w_kb = 4'd8;
        end else begin
            w_kb = r_key_bytes;
        end
        if (r_bucket_cnt == 7'd0) begin
            w_div = DW'(1);
        end else if (32'(r_bucket_cnt) > MAX_BUCKETS) begin
            w_div = DW'(MAX_BUCKETS);
        end else begin
            w_div = DW'(r_bucket_cnt);
        end
    end

    assign w_accept    = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    cht_mod #(.DW(DW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (i_key & cht_pkg::key_mask(w_kb)),
        .i_divisor  (w_div),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    // Pool slots below the low-water mark were never written since reset and
    // still hold their own index.
    assign w_pop_idx = IW'(r_free_cnt - LW'(1));
    assign w_new     = (LW'(w_pop_idx) < r_mark) ? w_pop_idx : w_free_rd;

    always_comb begin
        w_rm_head  = (r_prev == NONE) ? r_nx : r_head;
        w_rm_tail  = (32'(r_nx) >= ENTRIES) ? r_prev : r_tail;
        w_ins_head = (32'(r_tail) >= ENTRIES) ? LW'(r_new) : r_head;
    end

    // Memory port control.
    always_comb begin
        w_bkt_re     = (r_state == S_MOD) && w_mod_done;
        w_bkt_raddr  = w_rem[BW-1:0];
        w_bkt_we     = 1'b0;
        w_bkt_wdata  = {w_ins_head, LW'(r_new)};
        w_ent_re     = (r_state == S_WALK);
        w_key_we     = (r_state == S_POP);
        w_val_we     = 1'b0;
        w_val_waddr  = w_new;
        w_next_we    = 1'b0;
        w_next_waddr = w_new;
        w_next_wdata = NONE;
        w_free_we    = 1'b0;
        w_free_re    = 1'b0;
        case (r_state)
            S_ACT: begin
                if (r_req == cht_pkg::REQ_SET) begin
                    if (r_hit) begin
                        w_val_we    = 1'b1;
                        w_val_waddr = r_cur[IW-1:0];
                    end else begin
                        w_free_re = 1'b1;
                    end
                end else if (r_req == cht_pkg::REQ_REMOVE && r_hit) begin
                    w_bkt_we     = 1'b1;
                    w_bkt_wdata  = {w_rm_head, w_rm_tail};
                    w_next_we    = (r_prev != NONE);
                    w_next_waddr = r_prev[IW-1:0];
                    w_next_wdata = r_nx;
                    w_free_we    = (32'(r_free_cnt) < ENTRIES);
                end
            end
            S_POP: begin
                w_val_we  = 1'b1;
                w_next_we = 1'b1;
            end
            S_INS: begin
                w_bkt_we     = 1'b1;
                w_next_we    = (32'(r_tail) < ENTRIES);
                w_next_waddr = r_tail[IW-1:0];
                w_next_wdata = LW'(r_new);
            end
            default: begin
            end
        endcase
    end

    cht_ram #(.WIDTH(2*LW), .DEPTH(MAX_BUCKETS)) u_bkt_ram (
        .i_clk(i_clk), .i_we(w_bkt_we), .i_waddr(r_bkt), .i_wdata(w_bkt_wdata),
        .i_re(w_bkt_re), .i_raddr(w_bkt_raddr), .o_rdata(w_bkt_rd)
    );

    cht_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk(i_clk), .i_we(w_key_we), .i_waddr(w_new), .i_wdata(r_key),
        .i_re(w_ent_re), .i_raddr(r_cur[IW-1:0]), .o_rdata(w_key_rd)
    );

    cht_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk(i_clk), .i_we(w_val_we), .i_waddr(w_val_waddr), .i_wdata(r_val_in),
        .i_re(w_ent_re), .i_raddr(r_cur[IW-1:0]), .o_rdata(w_val_rd)
    );

    cht_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next_ram (
        .i_clk(i_clk), .i_we(w_next_we), .i_waddr(w_next_waddr),
        .i_wdata(w_next_wdata), .i_re(w_ent_re), .i_raddr(r_cur[IW-1:0]),
        .o_rdata(w_next_rd)
    );

    cht_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_free_ram (
        .i_clk(i_clk), .i_we(w_free_we), .i_waddr(r_free_cnt[IW-1:0]),
        .i_wdata(r_cur[IW-1:0]), .i_re(w_free_re), .i_raddr(w_pop_idx),
        .o_rdata(w_free_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key_bytes  <= cht_pkg::DEFAULT_KEY_BYTES;
            r_bucket_cnt <= cht_pkg::DEFAULT_BUCKETS;
            r_free_cnt   <= NONE;
            r_mark       <= NONE;
            r_bvalid     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == cht_pkg::CFG_KEY_BYTES) begin
                    r_key_bytes <= i_cfg_data[3:0];
                end else begin
                    r_bucket_cnt <= i_cfg_data;
                end
            end
            if (r_state == S_OUT && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req    <= i_req_type;
                        r_key    <= i_key & cht_pkg::key_mask(w_kb);
                        r_val_in <= i_value_in;
                        r_state  <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_bkt   <= w_rem[BW-1:0];
                        r_state <= S_BKT;
                    end
                end
                S_BKT: begin
                    // Buckets never written since reset read as empty chains.
                    if (r_bvalid[r_bkt]) begin
                        r_head <= w_bkt_rd[2*LW-1:LW];
                        r_tail <= w_bkt_rd[LW-1:0];
                        r_cur  <= w_bkt_rd[2*LW-1:LW];
                    end else begin
                        r_head <= NONE;
                        r_tail <= NONE;
                        r_cur  <= NONE;
                    end
                    r_prev  <= NONE;
                    r_steps <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (32'(r_cur) >= ENTRIES || 32'(r_steps) >= ENTRIES) begin
                        r_hit   <= 1'b0;
                        r_state <= S_ACT;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_key_rd == r_key) begin
                        r_hit   <= 1'b1;
                        r_val   <= w_val_rd;
                        r_nx    <= w_next_rd;
                        r_state <= S_ACT;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= w_next_rd;
                        r_steps <= r_steps + LW'(1);
                        r_state <= S_WALK;
                    end
                end
                S_ACT: begin
                    case (r_req)
                        cht_pkg::REQ_SET: begin
                            r_res_val <= '0;
                            if (r_hit) begin
                                r_res_status <= cht_pkg::ST_UPDATED;
                                r_res_found  <= 1'b1;
                                r_state      <= S_OUT;
                            end else if (r_free_cnt == '0) begin
                                r_res_status <= cht_pkg::ST_FULL;
                                r_res_found  <= 1'b0;
                                r_state      <= S_OUT;
                            end else begin
                                r_res_found <= 1'b0;
                                r_state     <= S_POP;
                            end
                        end
                        cht_pkg::REQ_GET: begin
                            r_res_status <= r_hit ? cht_pkg::ST_FOUND : cht_pkg::ST_NOTFOUND;
                            r_res_found  <= r_hit;
                            r_res_val    <= r_hit ? r_val : '0;
                            r_state      <= S_OUT;
                        end
                        cht_pkg::REQ_REMOVE: begin
                            r_res_status <= r_hit ? cht_pkg::ST_FOUND : cht_pkg::ST_NOTFOUND;
                            r_res_found  <= r_hit;
                            r_res_val    <= '0;
                            r_state      <= S_OUT;
                            if (r_hit) begin
                                r_bvalid[r_bkt] <= 1'b1;
                                if (32'(r_free_cnt) < ENTRIES) begin
                                    r_free_cnt <= r_free_cnt + LW'(1);
                                end
                            end
                        end
                        default: begin
                            r_res_status <= cht_pkg::ST_NOTFOUND;
                            r_res_found  <= 1'b0;
                            r_res_val    <= '0;
                            r_state      <= S_OUT;
                        end
                    endcase
                end
                S_POP: begin
                    r_new        <= w_new;
                    r_free_cnt   <= r_free_cnt - LW'(1);
                    if (LW'(w_pop_idx) < r_mark) begin
                        r_mark <= LW'(w_pop_idx);
                    end
                    r_res_status <= cht_pkg::ST_INSERTED;
                    r_state      <= S_INS;
                end
                S_INS: begin
                    r_bvalid[r_bkt] <= 1'b1;
                    r_state         <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_status <= r_res_status;
                        r_found  <= r_res_found;
                        r_vout   <= r_res_val;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_value_out = r_vout;

    `CHK_ALWAYS(a_free_bound, 32'(r_free_cnt) <= ENTRIES, "free count above pool size")
    `CHK_ALWAYS(a_mark_order, r_mark <= r_free_cnt, "pool low-water mark above free count")
    `CHK_NEXT(a_accept_start, w_accept, r_state == S_MOD, "accepted item did not start")

endmodule
